[hw/rtl/lme_pkg.sv]
// package for the life evaluator: types, codes and the life step function
package lme_pkg;

  localparam int unsigned MaxVisitedDefault = 256;
  localparam int unsigned BoardW = 64;
  localparam int unsigned WinW = 4;

  typedef enum logic [1:0] {
    ReasonDied  = 2'd0,
    ReasonStill = 2'd1,
    ReasonCycle = 2'd2,
    ReasonFull  = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic         fits;
    logic [63:0]  next;
  } step_t;

  function automatic logic [63:0] life_step(input logic [63:0] b);
    logic [63:0] nx;
    logic [3:0]  n;
    nx = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        n = '0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr <= 7 &&
                c + dc >= 0 && c + dc <= 7) begin
              n = n + {3'd0, b[(r + dr) * 8 + c + dc]};
            end
          end
        end
        nx[r * 8 + c] = (n == 4'd3) || (b[r * 8 + c] && n == 4'd2);
      end
    end
    return nx;
  endfunction

  function automatic logic fits_window(input logic [63:0] b, input logic [3:0] w,
                                       input logic [3:0] h);
    logic [7:0] rows;
    logic [7:0] cols;
    logic [3:0] rmin, rmax, cmin, cmax;
    rows = '0;
    cols = '0;
    for (int r = 0; r < 8; r++) begin
      rows[r] = |b[r * 8 +: 8];
      for (int c = 0; c < 8; c++) cols[c] = cols[c] | b[r * 8 + c];
    end
    rmin = 4'd8; rmax = 4'd0; cmin = 4'd8; cmax = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rows[i]) rmin = 4'(i);
      if (cols[i]) cmin = 4'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (rows[i]) rmax = 4'(i);
      if (cols[i]) cmax = 4'(i);
    end
    return (b != '0) && ((cmax - cmin + 4'd1) <= w) && ((rmax - rmin + 4'd1) <= h);
  endfunction

endpackage

[hw/rtl/lme_step_unit.sv]
// registered life step and window fit unit shared across generations
module lme_step_unit (
  input  logic                 clk_i,
  input  logic [63:0]          board_i,
  input  logic [3:0]           win_w_i,
  input  logic [3:0]           win_h_i,
  output lme_pkg::step_t       step_o
);

  lme_pkg::step_t step_q;

  always_ff @(posedge clk_i) begin
    step_q.next <= lme_pkg::life_step(board_i);
    step_q.fits <= lme_pkg::fits_window(board_i, win_w_i, win_h_i);
  end

  assign step_o = step_q;

endmodule

[hw/rtl/lme_visit_mem.sv]
// visited board store, one write and one registered read per cycle
module lme_visit_mem #(
  parameter int unsigned Depth = lme_pkg::MaxVisitedDefault,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/life_methuselah_evaluator.sv]
// top level of the life methuselah evaluator
// An 8x8 start board enters on the input channel (start_board_i, in_valid_i,
// in_stall_o). The block then runs life generations one at a time through a
// single registered step unit and scans the visited store one entry per cycle
// through its single read port looking for a repeat. Each generation passes
// the step and evaluate states, then the scan and compare states over the stored
// boards; it ends at evaluate when the run dies out or stands still. The
// visited store scan dominates the run time.
// One result item leaves on the output channel with generation_count_o,
// end_reason_o, coverable_found_o and first_coverable_generation_o.
// in_stall_o stays high from acceptance until the result has been taken.
// The result register holds while out_stall_i is high.
// Window registers are written through cfg_we_i, cfg_idx_i, cfg_data_i
// and reset to width 7, height 5. Reset empties the block and drops
// out_valid_o; no clearing pass is needed since only written entries are read.
module life_methuselah_evaluator #(
  parameter int unsigned MaxVisited = lme_pkg::MaxVisitedDefault,
  localparam int unsigned AW = $clog2(MaxVisited),
  localparam int unsigned CW = AW + 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] start_board_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  generation_count_o,
  output logic [1:0]  end_reason_o,
  output logic        coverable_found_o,
  output logic [7:0]  first_coverable_generation_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StStep  = 6'b000010,
    StEval  = 6'b000100,
    StScan  = 6'b001000,
    StCmp   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] win_w_q, win_h_q;
  logic [63:0] board_q, board_d;
  logic [63:0] next_q, next_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic fit_q, fit_d;
  logic [7:0] first_q, first_d;
  logic [1:0] reason_q, reason_d;
  lme_pkg::step_t step;
  logic [63:0] rdata;
  logic mem_we;
  logic [3:0] win_w_eff, win_h_eff;
  logic [CW-1:0] rd_ptr;

  assign win_w_eff = win_w_q;
  assign win_h_eff = win_h_q;

  lme_step_unit u_step (
    .clk_i   (clk_i),
    .board_i (board_q),
    .win_w_i (win_w_eff),
    .win_h_i (win_h_eff),
    .step_o  (step)
  );

  lme_visit_mem #(.Depth(MaxVisited)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (board_q),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= 4'd7;
      win_h_q <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lme_pkg::CfgWidth:  win_w_q <= cfg_data_i;
        lme_pkg::CfgHeight: win_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mem_we = (state_q == StEval);

  always_comb begin
    state_d  = state_q;
    board_d  = board_q;
    next_d   = next_q;
    count_d  = count_q;
    scan_d   = scan_q;
    fit_d    = fit_q;
    first_d  = first_q;
    reason_d = reason_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          board_d = start_board_i;
          count_d = '0;
          fit_d   = 1'b0;
          first_d = '0;
          state_d = StStep;
        end
      end
      StStep: state_d = StEval;
      StEval: begin
        if (!fit_q && step.fits) begin
          fit_d   = 1'b1;
          first_d = 8'(count_q);
        end
        count_d = count_q + CW'(1);
        next_d  = step.next;
        scan_d  = '0;
        if (step.next == '0) begin
          reason_d = lme_pkg::ReasonDied;
          state_d  = StOut;
        end else if (step.next == board_q) begin
          reason_d = lme_pkg::ReasonStill;
          state_d  = StOut;
        end else begin
          state_d = StScan;
        end
      end
      StScan: state_d = StCmp;
      StCmp: begin
        if (rdata == next_q) begin
          reason_d = lme_pkg::ReasonCycle;
          state_d  = StOut;
        end else if (scan_q + CW'(1) < count_q) begin
          scan_d  = scan_q + CW'(1);
          state_d = StCmp;
        end else if (count_q >= CW'(MaxVisited)) begin
          reason_d = lme_pkg::ReasonFull;
          state_d  = StOut;
        end else begin
          board_d = next_q;
          state_d = StStep;
        end
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // the read address is the next scan index, so the registered read data meets the compare in the following cycle
  assign rd_ptr = scan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    board_q  <= board_d;
    next_q   <= next_d;
    count_q  <= count_d;
    scan_q   <= rd_ptr;
    fit_q    <= fit_d;
    first_q  <= first_d;
    reason_q <= reason_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign generation_count_o = 9'(count_q);
  assign end_reason_o = reason_q;
  assign coverable_found_o = fit_q;
  assign first_coverable_generation_o = fit_q ? first_q : 8'd0;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(generation_count_o))
    else $error("result dropped under stall");
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q != '0 && count_q <= CW'(MaxVisited))
    else $error("count out of range");

endmodule

[tb/life_methuselah_evaluator_tb.sv]
// testbench for the life methuselah evaluator: random and directed boards vs a predictor
module life_methuselah_evaluator_tb;

  typedef struct {
    logic [8:0]       gens;
    lme_pkg::reason_e reason;
    logic             found;
    logic [7:0]       first_gen;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] start_board_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [8:0]  generation_count_o;
  logic [1:0]  end_reason_o;
  logic        coverable_found_o;
  logic [7:0]  first_coverable_generation_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [3:0]  cfg_data_i;

  life_methuselah_evaluator u_dut (.*);

  logic [63:0] pending_boards[$];
  verdict_t    expected_verdicts[$];
  logic [3:0]  win_w;
  logic [3:0]  win_h;
  int          mismatches;
  int          boards_sent;
  int          verdicts_seen;
  longint      cycle_count;
  int          send_gap;
  int          take_gap;
  bit          quiet_phase;
  int          reason_hits[4];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] next_generation(input logic [63:0] b);
    logic [63:0] nx;
    int n;
    nx = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        n = 0;
        for (int rr = r - 1; rr <= r + 1; rr++) begin
          for (int cc = c - 1; cc <= c + 1; cc++) begin
            if ((rr != r || cc != c) && rr >= 0 && rr < 8 && cc >= 0 && cc < 8)
              n += b[rr * 8 + cc];
          end
        end
        nx[r * 8 + c] = (n == 3) || (b[r * 8 + c] && n == 2);
      end
    end
    return nx;
  endfunction

  function automatic bit board_in_window(input logic [63:0] b);
    int rlo, rhi, clo, chi;
    rlo = 8; rhi = -1; clo = 8; chi = -1;
    if (b == '0) return 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (b[i]) begin
        if (i / 8 < rlo) rlo = i / 8;
        if (i / 8 > rhi) rhi = i / 8;
        if (i % 8 < clo) clo = i % 8;
        if (i % 8 > chi) chi = i % 8;
      end
    end
    return (chi - clo + 1 <= int'(win_w)) && (rhi - rlo + 1 <= int'(win_h));
  endfunction

  function automatic verdict_t evolve_board(input logic [63:0] start);
    logic [63:0] seen[$];
    logic [63:0] cur;
    logic [63:0] nx;
    verdict_t v;
    bit repeat_hit;
    cur = start;
    v.found = 1'b0;
    v.first_gen = '0;
    forever begin
      if (!v.found && board_in_window(cur)) begin
        v.found = 1'b1;
        v.first_gen = 8'(seen.size());
      end
      seen.push_back(cur);
      nx = next_generation(cur);
      repeat_hit = 1'b0;
      foreach (seen[i]) if (seen[i] == nx) repeat_hit = 1'b1;
      if (nx == '0) begin v.reason = lme_pkg::ReasonDied; break; end
      if (nx == cur) begin v.reason = lme_pkg::ReasonStill; break; end
      if (repeat_hit) begin v.reason = lme_pkg::ReasonCycle; break; end
      if (seen.size() >= lme_pkg::MaxVisitedDefault) begin
        v.reason = lme_pkg::ReasonFull;
        break;
      end
      cur = nx;
    end
    v.gens = 9'(seen.size());
    return v;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      start_board_i <= '0;
      send_gap <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_verdicts.push_back(evolve_board(start_board_i));
      boards_sent <= boards_sent + 1;
      in_valid_i <= 1'b0;
      send_gap <= quiet_phase ? 0 : $urandom_range(0, 6);
    end else if (!in_valid_i) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_boards.size() > 0) begin
        start_board_i <= pending_boards.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        verdicts_seen <= verdicts_seen + 1;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: count %0d", generation_count_o);
        end else begin
          v = expected_verdicts.pop_front();
          reason_hits[v.reason]++;
          if (generation_count_o !== v.gens || end_reason_o !== v.reason ||
              coverable_found_o !== v.found ||
              first_coverable_generation_o !== v.first_gen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       v.gens, v.reason, v.found, v.first_gen, generation_count_o,
                       end_reason_o, coverable_found_o, first_coverable_generation_o);
          end
        end
        take_gap <= quiet_phase ? 0 : $urandom_range(0, 6);
        out_stall_i <= !quiet_phase;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // timeout guard on the total cycle count, set high enough for every item to run at full length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 100_000_000) begin
      $display("timeout");
      $display("life_methuselah_evaluator_tb NOT OK");
      $finish;
    end
  end

  task automatic set_window(input logic [3:0] w, input logic [3:0] h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= lme_pkg::CfgWidth; cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= lme_pkg::CfgHeight; cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_w = w;
    win_h = h;
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    while (pending_boards.size() > 0 || in_valid_i || expected_verdicts.size() > 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_board();
    logic [63:0] b;
    int kind;
    int r, c;
    kind = $urandom_range(0, 9);
    b = {$urandom(), $urandom()};
    if (kind < 3) b = b & {$urandom(), $urandom()} & {$urandom(), $urandom()};
    else if (kind < 6) begin
      r = $urandom_range(0, 5); c = $urandom_range(0, 5);
      b = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          b[(r + i) * 8 + c + j] = $urandom_range(0, 1);
    end else if (kind == 6) b = ~(b & {$urandom(), $urandom()});
    return b;
  endfunction

  task automatic run_phase(input int n);
    repeat (n) pending_boards.push_back(random_board());
    drain_all();
  endtask

  initial begin
    logic [3:0] widths[6];
    logic [3:0] heights[6];
    widths = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd15, 4'd12};
    heights = '{4'd8, 4'd0, 4'd2, 4'd8, 4'd15, 4'd1};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = lme_pkg::CfgWidth; cfg_data_i = '0;
    mismatches = 0; boards_sent = 0; verdicts_seen = 0; cycle_count = 0;
    quiet_phase = 1'b0;
    win_w = 4'd7; win_h = 4'd5;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed boards under reset window
    pending_boards.push_back(64'h0);
    pending_boards.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_boards.push_back(64'h1);
    pending_boards.push_back(64'h8000_0000_0000_0000);
    pending_boards.push_back(64'h0303);                  // block
    pending_boards.push_back(64'h0007_0000);             // blinker
    pending_boards.push_back(64'h0001_0507 << 8);        // six-cell pattern
    pending_boards.push_back(64'h0000_0000_0006_0C04);   // r-pentomino-like
    pending_boards.push_back(64'h8100_0000_0000_0081);
    pending_boards.push_back(64'h5555_5555_5555_5555);
    pending_boards.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_boards.push_back(64'h0000_0018_1800_0000);
    pending_boards.push_back(64'h0000_0000_0000_00FF);
    pending_boards.push_back(64'h0102_0408_1020_4080);
    drain_all();
    run_phase(100);
    foreach (widths[i]) begin
      set_window(widths[i], heights[i]);
      quiet_phase = (i == 2);
      run_phase(80);
    end
    $display("%0d boards evaluated over 7 window settings, end reasons died %0d still %0d",
             verdicts_seen, reason_hits[0], reason_hits[1]);
    $display("cycle %0d full %0d, %0d mismatches", reason_hits[2], reason_hits[3], mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("life_methuselah_evaluator_tb OK");
    else
      $display("life_methuselah_evaluator_tb NOT OK");
    $finish;
  end

endmodule
